// File: hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

	// Port widths fixed by the transaction format
	localparam int CMD_W      = 3;
	localparam int POS_W      = 7;
	localparam int KEY_PORT_W = 16;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;

	// Widest list index over the supported capacity range (up to 1024 entries)
	localparam int IDX_MAX_W  = 11;

	// Default sizing
	localparam int DEF_CAPACITY = 64;
	localparam int DEF_KEY_BITS = 16;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_INS_POS  = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_TAIL = 3'd2,
		CMD_RM_POS   = 3'd3,
		CMD_RM_HEAD  = 3'd4,
		CMD_RM_TAIL  = 3'd5,
		CMD_SEARCH   = 3'd6
	} cmd_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Per-cell operation broadcast down the row
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2
	} cell_op_t;

	// Control group shared by every cell in the row
	typedef struct packed {
		cell_op_t               op;
		logic [IDX_MAX_W-1:0]   pos;
		logic [IDX_MAX_W-1:0]   len;
	} cell_ctl_t;

endpackage

// File: hdl/ple_cell.sv
// One slot of the list: holds a key, shifts toward either neighbor, compares for search.
module ple_cell #(
	parameter int KEY_BITS = 16,
	parameter int IDX      = 0
) (
	input  logic                  clk,
	input  ple_pkg::cell_ctl_t    ctl,
	input  logic [KEY_BITS-1:0]   key_in,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic [KEY_BITS-1:0]   right_key,
	output logic [KEY_BITS-1:0]   key_q,
	output logic [KEY_BITS-1:0]   pick,
	output logic                  match
);
	import ple_pkg::*;

	logic [IDX_MAX_W-1:0] my_idx;
	logic [KEY_BITS-1:0]  key_d;

	assign my_idx = IDX_MAX_W'(IDX);

	// Select next content: shift back on insert, close the gap on remove
	always_comb begin
		key_d = key_q;
		case (ctl.op)
			CELL_INS: begin
				if (my_idx > ctl.pos) begin
					key_d = left_key;
				end else if (my_idx == ctl.pos) begin
					key_d = key_in;
				end
			end
			CELL_DEL: begin
				if (my_idx >= ctl.pos) begin
					key_d = right_key;
				end
			end
			default: begin
				key_d = key_q;
			end
		endcase
	end

	// Hold the slot contents
	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	// Offer this key when the target position lands here
	assign pick  = (my_idx == ctl.pos) ? key_q : '0;

	// Flag a search hit only inside the occupied part of the list
	assign match = (key_q == key_in) && (my_idx < ctl.len);

endmodule

// File: hdl/positional_list_engine_unit.sv
// Top level of the positional list engine: command decode, cell row and result stages.
//
// Usage:
//   A command transaction is taken at each rising edge where start is high and
//   busy is low. busy stays low: the row of cells applies an insert, remove or
//   search in the same edge that takes the transaction, so a new command may
//   follow in every cycle (one transaction per cycle sustained).
//   Each command gives exactly one result: done is high for one cycle and
//   status, removed_key, found and entry_count are valid in that cycle. The
//   result passes through the stage 1 and stage 2 registers: stage 1 latches
//   status and the per-cell search hits, stage 2 merges the hits.
//   Results are always taken by the receiver; it cannot stall them.
//   Reset clears the list length and the result strobe; slot contents are
//   left as they are and are never read outside the occupied part.
//   Every slot is a cell that only talks to its neighbors, so the whole list
//   shifts at the edge that takes the transaction, regardless of capacity.
module positional_list_engine_unit #(
	parameter int CAPACITY = ple_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = ple_pkg::DEF_KEY_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ple_pkg::CMD_W-1:0]         command,
	input  logic [ple_pkg::POS_W-1:0]         position,
	input  logic [ple_pkg::KEY_PORT_W-1:0]    entry_key,
	output logic                              done,
	output logic [ple_pkg::STATUS_W-1:0]      status,
	output logic [ple_pkg::KEY_PORT_W-1:0]    removed_key,
	output logic                              found,
	output logic [ple_pkg::COUNT_W-1:0]       entry_count
);
	import ple_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// List state and cell row
	logic [CNT_W-1:0]    len_q;
	logic [KEY_BITS-1:0] key_b;
	logic [KEY_BITS-1:0] cell_key  [CAPACITY];
	logic [KEY_BITS-1:0] cell_pick [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	cell_ctl_t           ctl;

	// Decode results
	logic                accept;
	logic [CMP_W-1:0]    pos_w;
	logic [CMP_W-1:0]    len_w;
	logic                full;
	logic                empty;
	status_t             st_d;
	cell_op_t            op_d;
	logic [CNT_W-1:0]    tgt_d;
	logic [CNT_W-1:0]    len_d;
	logic                rm_d;
	logic                srch_d;
	logic [KEY_BITS-1:0] pick_or;

	// Result stages
	logic                done_s1;
	logic                srch_s1;
	status_t             status_s1;
	logic [KEY_PORT_W-1:0] removed_s1;
	logic [COUNT_W-1:0]  count_s1;
	logic [CAPACITY-1:0] match_s1;
	logic                done_s2;
	status_t             status_s2;
	logic [KEY_PORT_W-1:0] removed_s2;
	logic                found_s2;
	logic [COUNT_W-1:0]  count_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign key_b  = KEY_BITS'(entry_key);
	assign pos_w  = CMP_W'(position);
	assign len_w  = CMP_W'(len_q);
	assign full   = (len_q == CNT_W'(CAPACITY));
	assign empty  = (len_q == '0);

	// Decode command, check bounds, pick the cell operation
	always_comb begin
		st_d   = ST_OK;
		op_d   = CELL_HOLD;
		tgt_d  = '0;
		len_d  = len_q;
		rm_d   = 1'b0;
		srch_d = 1'b0;
		unique case (command) inside
			CMD_INS_POS: begin
				if (pos_w > len_w) begin
					st_d = ST_BADPOS;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					op_d  = CELL_INS;
					tgt_d = CNT_W'(position);
					len_d = len_q + 1'b1;
				end
			end
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					op_d  = CELL_INS;
					tgt_d = (command == CMD_INS_TAIL) ? len_q : '0;
					len_d = len_q + 1'b1;
				end
			end
			CMD_RM_POS: begin
				rm_d = 1'b1;
				if (empty) begin
					st_d = ST_EMPTY;
				end else if (pos_w >= len_w) begin
					st_d = ST_BADPOS;
				end else begin
					op_d  = CELL_DEL;
					tgt_d = CNT_W'(position);
					len_d = len_q - 1'b1;
				end
			end
			CMD_RM_HEAD, CMD_RM_TAIL: begin
				rm_d = 1'b1;
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					op_d  = CELL_DEL;
					tgt_d = (command == CMD_RM_TAIL) ? (len_q - 1'b1) : '0;
					len_d = len_q - 1'b1;
				end
			end
			CMD_SEARCH: begin
				srch_d = 1'b1;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	// Broadcast to the row; hold everything when no transaction is taken
	always_comb begin
		ctl.op  = accept ? op_d : CELL_HOLD;
		ctl.pos = IDX_MAX_W'(tgt_d);
		ctl.len = IDX_MAX_W'(len_q);
	end

	// Build the row of cells, each wired to its neighbors (zero beyond either end)
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_BITS-1:0] left_k;
		logic [KEY_BITS-1:0] right_k;

		if (g == 0) begin : g_first
			assign left_k = '0;
		end else begin : g_inner_l
			assign left_k = cell_key[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_k = '0;
		end else begin : g_inner_r
			assign right_k = cell_key[g+1];
		end

		ple_cell #(
			.KEY_BITS (KEY_BITS),
			.IDX      (g)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key_in    (key_b),
			.left_key  (left_k),
			.right_key (right_k),
			.key_q     (cell_key[g]),
			.pick      (cell_pick[g]),
			.match     (cell_match[g])
		);
	end

	// Merge the one-hot picks into the key at the target position
	always_comb begin
		pick_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_or = pick_or | cell_pick[i];
		end
	end

	// Advance the list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			len_q <= len_d;
		end
	end

	// Stage 1 control: result pending and search flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			srch_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			srch_s1 <= accept && srch_d;
		end
	end

	// Stage 1 payload: status, removed key, count, per-cell hits
	always_ff @(posedge clk) begin
		status_s1  <= st_d;
		removed_s1 <= (rm_d && (st_d == ST_OK)) ? KEY_PORT_W'(pick_or) : '0;
		count_s1   <= COUNT_W'(len_d);
		match_s1   <= cell_match;
	end

	// Stage 2 control: result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= done_s1;
		end
	end

	// Stage 2 payload: reduce the search hits
	always_ff @(posedge clk) begin
		status_s2  <= status_s1;
		removed_s2 <= removed_s1;
		found_s2   <= srch_s1 && (|match_s1);
		count_s2   <= count_s1;
	end

	assign done        = done_s2;
	assign status      = status_s2;
	assign removed_key = removed_s2;
	assign found       = found_s2;
	assign entry_count = count_s2;

endmodule
